### src/alx_pkg.sv
// Shared types and constants of the arithmetic expression lexer.
package alx_pkg;

	localparam int MAX_DIGITS = 18;
	localparam int MAX_DEPTH  = 255;

	localparam int DEPTH_W = $clog2(MAX_DEPTH + 1);
	localparam int DCNT_W  = $clog2(MAX_DIGITS + 1);
	localparam int MANT_W  = 60;
	localparam int FRAC_W  = 5;
	localparam int CHAR_W  = 8;
	localparam int OPN_W   = 2;
	localparam int KIND_W  = 2;
	localparam int DATA_W  = 80;

	localparam logic [CHAR_W-1:0] CH_TILDE = 8'h7E;
	localparam logic [CHAR_W-1:0] CH_OPEN  = 8'h28;
	localparam logic [CHAR_W-1:0] CH_CLOSE = 8'h29;
	localparam logic [CHAR_W-1:0] CH_POINT = 8'h2E;
	localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
	localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
	localparam logic [CHAR_W-1:0] CH_STAR  = 8'h2A;
	localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;
	localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

	typedef enum logic [OPN_W-1:0] {
		OPN_CHAR  = 2'd0,
		OPN_END   = 2'd1,
		OPN_CLEAR = 2'd2
	} opn_t;

	typedef enum logic [KIND_W-1:0] {
		TK_NONE     = 2'd0,
		TK_NUMBER   = 2'd1,
		TK_OPERATOR = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		LS_OP     = 3'd0,
		LS_NUM    = 3'd1,
		LS_POINT  = 3'd2,
		LS_FRAC   = 3'd3,
		LS_UMINUS = 3'd4,
		LS_CLOSE  = 3'd5,
		LS_ERR    = 3'd6
	} lex_state_t;

	typedef struct packed {
		logic                accepted;
		kind_t               kind;
		logic [MANT_W-1:0]   mantissa;
		logic [FRAC_W-1:0]   frac;
		logic                too_long;
		logic [CHAR_W-1:0]   opc;
	} res_t;

	// Results of one input: one or two items.
	typedef struct packed {
		logic two;
		res_t first;
		res_t second;
	} res_pair_t;

endpackage

### src/alx_core.sv
// Lexer state registers and the single-pass step logic for one input beat.
module alx_core
	import alx_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic [OPN_W-1:0]    operation,
	input  logic [CHAR_W-1:0]   char_code,
	output res_pair_t           res
);

	lex_state_t          state_q, state_d;
	logic [DEPTH_W-1:0]  depth_q, depth_d;
	logic [MANT_W-1:0]   mant_q, mant_d;
	logic [FRAC_W-1:0]   frac_q, frac_d;
	logic [DCNT_W-1:0]   dcnt_q, dcnt_d;
	logic                ovf_q, ovf_d;
	logic                pend_q, pend_d;

	logic       is_dig, is_arith, refused;
	lex_state_t nxt;
	res_t       status_ok, status_bad, num_tok, zero_tok, op_tok;

	function automatic lex_state_t next_state(lex_state_t s, logic dig, logic arith,
			logic [CHAR_W-1:0] c);
		lex_state_t r;
		r = LS_ERR;
		unique case (s)
			LS_OP: begin
				if (dig) r = LS_NUM;
				else if (c == CH_MINUS) r = LS_UMINUS;
				else if (c == CH_OPEN) r = LS_OP;
			end
			LS_NUM: begin
				if (dig) r = LS_NUM;
				else if (arith) r = LS_OP;
				else if (c == CH_POINT) r = LS_POINT;
				else if (c == CH_CLOSE) r = LS_CLOSE;
			end
			LS_POINT: begin
				if (dig) r = LS_FRAC;
			end
			LS_FRAC: begin
				if (dig) r = LS_FRAC;
				else if (arith) r = LS_OP;
				else if (c == CH_CLOSE) r = LS_CLOSE;
			end
			LS_UMINUS: begin
				if (dig) r = LS_NUM;
				else if (c == CH_OPEN) r = LS_OP;
			end
			LS_CLOSE: begin
				if (arith) r = LS_OP;
				else if (c == CH_CLOSE) r = LS_CLOSE;
			end
			default: r = LS_ERR;
		endcase
		return r;
	endfunction

	assign is_dig   = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
	assign is_arith = (char_code == CH_PLUS) || (char_code == CH_MINUS) ||
	                  (char_code == CH_STAR) || (char_code == CH_SLASH);
	assign nxt      = next_state(state_q, is_dig, is_arith, char_code);
	assign refused  = (nxt == LS_ERR) || ((char_code == CH_CLOSE) && (depth_q == '0));

	always_comb begin
		status_ok  = '{accepted: 1'b1, kind: TK_NONE, mantissa: '0, frac: '0,
		               too_long: 1'b0, opc: '0};
		status_bad = status_ok;
		status_bad.accepted = 1'b0;
		num_tok = '{accepted: 1'b1, kind: TK_NUMBER, mantissa: mant_q, frac: frac_q,
		            too_long: ovf_q, opc: '0};
		zero_tok = '{accepted: 1'b1, kind: TK_NUMBER, mantissa: '0, frac: '0,
		             too_long: 1'b0, opc: '0};
		op_tok = '{accepted: 1'b1, kind: TK_OPERATOR, mantissa: '0, frac: '0,
		           too_long: 1'b0, opc: char_code};
	end

	always_comb begin
		state_d = state_q;
		depth_d = depth_q;
		mant_d  = mant_q;
		frac_d  = frac_q;
		dcnt_d  = dcnt_q;
		ovf_d   = ovf_q;
		pend_d  = pend_q;
		res.two    = 1'b0;
		res.first  = status_bad;
		res.second = status_bad;
		unique case (operation)
			OPN_CLEAR: begin
				state_d = LS_OP;
				depth_d = '0;
				mant_d  = '0;
				frac_d  = '0;
				dcnt_d  = '0;
				ovf_d   = 1'b0;
				pend_d  = 1'b0;
				res.first = status_ok;
			end
			OPN_END: begin
				if ((depth_q == '0) &&
				    (state_q == LS_NUM || state_q == LS_FRAC || state_q == LS_CLOSE)) begin
					if (pend_q) begin
						res.first = num_tok;
						mant_d = '0;
						frac_d = '0;
						dcnt_d = '0;
						ovf_d  = 1'b0;
						pend_d = 1'b0;
					end else begin
						res.first = status_ok;
					end
				end
			end
			OPN_CHAR: begin
				if (!refused) begin
					state_d = nxt;
					if (char_code == CH_OPEN && depth_q < DEPTH_W'(MAX_DEPTH))
						depth_d = depth_q + 1'b1;
					if (char_code == CH_CLOSE)
						depth_d = depth_q - 1'b1;
					if (nxt == LS_NUM || nxt == LS_POINT || nxt == LS_FRAC) begin
						pend_d = 1'b1;
						if (is_dig) begin
							if (dcnt_q < DCNT_W'(MAX_DIGITS)) begin
								// Multiply by ten as two shifted adds.
								mant_d = (mant_q << 3) + (mant_q << 1) +
								         MANT_W'(char_code[3:0]);
								dcnt_d = dcnt_q + 1'b1;
								if (nxt == LS_FRAC)
									frac_d = frac_q + 1'b1;
							end else begin
								ovf_d = 1'b1;
							end
						end
						res.first = status_ok;
					end else if (nxt == LS_OP || nxt == LS_CLOSE) begin
						if (state_q == LS_NUM || state_q == LS_FRAC) begin
							res.two    = 1'b1;
							res.first  = num_tok;
							res.second = op_tok;
							mant_d = '0;
							frac_d = '0;
							dcnt_d = '0;
							ovf_d  = 1'b0;
							pend_d = 1'b0;
						end else begin
							res.first = op_tok;
						end
					end else begin
						// Unary minus: a zero operand, then the negate operator.
						res.two    = 1'b1;
						res.first  = zero_tok;
						res.second = op_tok;
						res.second.opc = CH_TILDE;
					end
				end
			end
			default: res.first = status_bad;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= LS_OP;
			depth_q <= '0;
			mant_q  <= '0;
			frac_q  <= '0;
			dcnt_q  <= '0;
			ovf_q   <= 1'b0;
			pend_q  <= 1'b0;
		end else if (step) begin
			state_q <= state_d;
			depth_q <= depth_d;
			mant_q  <= mant_d;
			frac_q  <= frac_d;
			dcnt_q  <= dcnt_d;
			ovf_q   <= ovf_d;
			pend_q  <= pend_d;
		end
	end

endmodule

### src/alx_obuf.sv
// Two-slot result register that sends the one or two beats of an input in order.
module alx_obuf
	import alx_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      load,
	input  res_pair_t pair,
	output logic      can_load,
	output logic      out_valid,
	input  logic      out_ready,
	output res_t      out_res,
	output logic      out_last
);

	res_t head_q, tail_q;
	logic head_last_q;
	logic head_vld_q, tail_vld_q;
	logic take;

	assign take      = head_vld_q && out_ready;
	assign can_load  = !head_vld_q || (take && !tail_vld_q);
	assign out_valid = head_vld_q;
	assign out_res   = head_q;
	assign out_last  = head_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_vld_q <= 1'b0;
			tail_vld_q <= 1'b0;
		end else if (load) begin
			head_vld_q <= 1'b1;
			tail_vld_q <= pair.two;
		end else if (take) begin
			head_vld_q <= tail_vld_q;
			tail_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			head_q      <= pair.first;
			head_last_q <= !pair.two;
			tail_q      <= pair.second;
		end else if (take && tail_vld_q) begin
			head_q      <= tail_q;
			head_last_q <= 1'b1;
		end
	end

endmodule

### src/arithmetic_expression_lexer.sv
// Top level of the arithmetic expression lexer: input register, step logic, result register.
// Latency: an accepted beat is registered in the input stage, is stepped into the result
// register, and its first result beat is offered from there.
// Throughput: one input beat per cycle while m_tready stays high and each input gives one result beat;
// an input that gives two beats (operator after a number, unary minus) holds the single result port for both.
// Reset: arst_n clears the lexer to the after-operator state with depth zero and no number.
module arithmetic_expression_lexer
	import alx_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	// Input stream: one character, end of expression or clear per beat.
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [7:0]         s_tdata,   // [7:0] char_code
	input  logic [1:0]         s_tuser,   // [1:0] operation
	// Result stream: status, number token or operator token per beat.
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [DATA_W-1:0]  m_tdata,   // [0] accepted, [60:1] mantissa,
	                                      // [65:61] fraction_digits, [66] too_long,
	                                      // [74:67] operator_code, [79:75] zero
	output logic [1:0]         m_tuser,   // [1:0] token_kind
	output logic               m_tlast    // last
);

	// Input register stage. It frees up whenever its beat is stepped, so a new
	// beat can enter in the same cycle.
	logic              vld_s1;
	logic [OPN_W-1:0]  opn_s1;
	logic [CHAR_W-1:0] char_s1;

	logic      step;
	logic      can_load;
	res_pair_t pair;
	res_t      out_res;

	assign step     = vld_s1 && can_load;
	assign s_tready = !vld_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			opn_s1  <= s_tuser;
			char_s1 <= s_tdata;
		end
	end

	// The lexer state only advances when the result register can take the
	// whole result of the beat, so no result is ever dropped.
	alx_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.operation (opn_s1),
		.char_code (char_s1),
		.res       (pair)
	);

	alx_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (step),
		.pair      (pair),
		.can_load  (can_load),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (out_res),
		.out_last  (m_tlast)
	);

	assign m_tdata = {5'b0, out_res.opc, out_res.too_long, out_res.frac,
	                  out_res.mantissa, out_res.accepted};
	assign m_tuser = KIND_W'(out_res.kind);

endmodule

### tb/sv/tb.sv
// Self-checking testbench for the arithmetic expression lexer: stream stimulus and token scoreboard.
`timescale 1ns / 100ps

module tb
	import alx_pkg::*;
();

	// Operation code outside the defined set; the lexer must refuse it.
	localparam logic [OPN_W-1:0] OPN_UNUSED = 2'd3;

	// Characters that the transition table always refuses.
	localparam logic [CHAR_W-1:0] CH_LETTER_A = 8'h41;
	localparam logic [CHAR_W-1:0] CH_NUL      = 8'h00;
	localparam logic [CHAR_W-1:0] CH_ALL_ONES = 8'hFF;

	localparam logic [CHAR_W-1:0] ARITH_OPS [4] = '{CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH};

	localparam int ITEM_TARGET = 1450;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_CYCLES = 20;
	localparam int CYCLE_LIMIT = 400000;

	// One result beat, split into its fields.
	typedef struct {
		bit                  accepted;
		kind_t               kind;
		logic [MANT_W-1:0]   mantissa;
		logic [FRAC_W-1:0]   frac_digits;
		bit                  too_long;
		logic [CHAR_W-1:0]   opc;
		bit                  last;
	} token_t;

	// Tracks the lexer state, predicts the tokens of every accepted input beat
	// and checks the result stream against them in order.
	class lexeme_scoreboard;
		lex_state_t          lex_state = LS_OP;
		int unsigned         depth = 0;
		logic [MANT_W-1:0]   num_mant = '0;
		logic [FRAC_W-1:0]   num_frac = '0;
		int unsigned         num_digits = 0;
		bit                  num_overflow = 0;
		bit                  num_open = 0;
		token_t              awaited[$];
		int                  errors = 0;

		function void clear_number();
			num_mant = '0;
			num_frac = '0;
			num_digits = 0;
			num_overflow = 0;
			num_open = 0;
		endfunction

		function void add_token(bit acc, kind_t kind, logic [MANT_W-1:0] mant,
				logic [FRAC_W-1:0] frac, bit tl, logic [CHAR_W-1:0] opc, bit last);
			token_t t;
			t.accepted = acc;
			t.kind = kind;
			t.mantissa = mant;
			t.frac_digits = frac;
			t.too_long = tl;
			t.opc = opc;
			t.last = last;
			awaited.insert(awaited.size(), t);
		endfunction

		// Flushes the pending number (zeros when it was already flushed).
		function void add_number(bit last);
			add_token(1'b1, TK_NUMBER, num_mant, num_frac, num_overflow, '0, last);
			clear_number();
		endfunction

		function lex_state_t next_lex_state(lex_state_t s, logic [CHAR_W-1:0] ch);
			bit dig;
			bit arith;
			dig = ch >= CH_ZERO && ch <= CH_NINE;
			arith = ch inside {CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH};
			case (s)
				LS_OP: begin
					if (dig) return LS_NUM;
					if (ch == CH_MINUS) return LS_UMINUS;
					if (ch == CH_OPEN) return LS_OP;
				end
				LS_NUM: begin
					if (dig) return LS_NUM;
					if (arith) return LS_OP;
					if (ch == CH_POINT) return LS_POINT;
					if (ch == CH_CLOSE) return LS_CLOSE;
				end
				LS_POINT: begin
					if (dig) return LS_FRAC;
				end
				LS_FRAC: begin
					if (dig) return LS_FRAC;
					if (arith) return LS_OP;
					if (ch == CH_CLOSE) return LS_CLOSE;
				end
				LS_UMINUS: begin
					if (dig) return LS_NUM;
					if (ch == CH_OPEN) return LS_OP;
				end
				LS_CLOSE: begin
					if (arith) return LS_OP;
					if (ch == CH_CLOSE) return LS_CLOSE;
				end
				default: ;
			endcase
			return LS_ERR;
		endfunction

		// Notes an accepted input beat; returns 1 when the lexer takes it,
		// 0 when it is refused and leaves the state untouched.
		function bit note_input(logic [OPN_W-1:0] op, logic [CHAR_W-1:0] ch);
			lex_state_t nxt;
			lex_state_t was;
			if (op == OPN_CLEAR) begin
				lex_state = LS_OP;
				depth = 0;
				clear_number();
				add_token(1'b1, TK_NONE, '0, '0, 1'b0, '0, 1'b1);
				return 1'b1;
			end
			if (op == OPN_END) begin
				if (depth != 0 || !(lex_state inside {LS_NUM, LS_FRAC, LS_CLOSE})) begin
					add_token(1'b0, TK_NONE, '0, '0, 1'b0, '0, 1'b1);
					return 1'b0;
				end
				if (num_open)
					add_number(1'b1);
				else
					add_token(1'b1, TK_NONE, '0, '0, 1'b0, '0, 1'b1);
				return 1'b1;
			end
			if (op != OPN_CHAR) begin
				add_token(1'b0, TK_NONE, '0, '0, 1'b0, '0, 1'b1);
				return 1'b0;
			end

			nxt = next_lex_state(lex_state, ch);
			if (nxt == LS_ERR || (ch == CH_CLOSE && depth == 0)) begin
				add_token(1'b0, TK_NONE, '0, '0, 1'b0, '0, 1'b1);
				return 1'b0;
			end
			was = lex_state;
			lex_state = nxt;
			// The depth saturates: an open bracket at the top is taken but not counted.
			if (ch == CH_OPEN && depth < MAX_DEPTH)
				depth++;
			if (ch == CH_CLOSE)
				depth--;

			case (nxt)
				LS_NUM, LS_POINT, LS_FRAC: begin
					num_open = 1'b1;
					if (ch >= CH_ZERO && ch <= CH_NINE) begin
						if (num_digits < MAX_DIGITS) begin
							num_mant = num_mant * 10 + MANT_W'(ch - CH_ZERO);
							num_digits++;
							if (nxt == LS_FRAC)
								num_frac++;
						end else begin
							num_overflow = 1'b1;
						end
					end
					add_token(1'b1, TK_NONE, '0, '0, 1'b0, '0, 1'b1);
				end
				LS_OP, LS_CLOSE: begin
					if (was == LS_NUM || was == LS_FRAC)
						add_number(1'b0);
					add_token(1'b1, TK_OPERATOR, '0, '0, 1'b0, ch, 1'b1);
				end
				default: begin
					// Unary minus becomes "0 ~".
					add_token(1'b1, TK_NUMBER, '0, '0, 1'b0, '0, 1'b0);
					add_token(1'b1, TK_OPERATOR, '0, '0, 1'b0, CH_TILDE, 1'b1);
				end
			endcase
			return 1'b1;
		endfunction

		function void compare_field(string name, logic [63:0] want, logic [63:0] got);
			if (want !== got) begin
				$error("%s: expected %0d, got %0d", name, want, got);
				errors++;
			end
		endfunction

		function void check_token(token_t got);
			token_t want;
			if (awaited.size() == 0) begin
				$error("result beat with nothing awaited: kind %0d mantissa %0d opc %0d",
					got.kind, got.mantissa, got.opc);
				errors++;
				return;
			end
			want = awaited.pop_front();
			compare_field("accepted", 64'(want.accepted), 64'(got.accepted));
			compare_field("token_kind", 64'(want.kind), 64'(got.kind));
			compare_field("mantissa", 64'(want.mantissa), 64'(got.mantissa));
			compare_field("fraction_digits", 64'(want.frac_digits), 64'(got.frac_digits));
			compare_field("too_long", 64'(want.too_long), 64'(got.too_long));
			compare_field("operator_code", 64'(want.opc), 64'(got.opc));
			compare_field("last", 64'(want.last), 64'(got.last));
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               s_tvalid = 1'b0;
	logic               s_tready;
	logic [7:0]         s_tdata = '0;    // [7:0] char_code
	logic [1:0]         s_tuser = '0;    // [1:0] operation
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	logic [DATA_W-1:0]  m_tdata;         // [0] accepted, [60:1] mantissa,
	                                     // [65:61] fraction_digits, [66] too_long,
	                                     // [74:67] operator_code, [79:75] zero
	logic [1:0]         m_tuser;         // [1:0] token_kind
	logic               m_tlast;

	lexeme_scoreboard   board = new;
	token_t             seen;
	logic [CHAR_W-1:0]  expr_chars[$];
	int                 send_idle_pct = 0;
	int                 recv_stall_pct = 0;
	bit                 hold_request = 1'b0;
	int                 accepted_items = 0;
	int                 cycle_count = 0;

	arithmetic_expression_lexer uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Result side: check every beat taken, then pick the next ready level.
	// A hold request keeps ready low for a long stretch so the lexer backs up.
	always begin
		@(posedge clk);
		if (arst_n && m_tvalid && m_tready) begin
			seen.accepted = m_tdata[0];
			seen.mantissa = m_tdata[60:1];
			seen.frac_digits = m_tdata[65:61];
			seen.too_long = m_tdata[66];
			seen.opc = m_tdata[74:67];
			seen.kind = kind_t'(m_tuser);
			seen.last = m_tlast;
			board.check_token(seen);
		end
		if (hold_request) begin
			hold_request = 1'b0;
			m_tready <= 1'b0;
			repeat (HOLD_CYCLES) @(posedge clk);
		end
		m_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Offers one beat, with random idle cycles first, and returns at the edge
	// where it is taken. Must be called right after a rising edge.
	task automatic send_beat(input logic [OPN_W-1:0] op, input logic [CHAR_W-1:0] ch);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= ch;
		do @(posedge clk); while (!s_tready);
		if (board.note_input(op, ch))
			accepted_items++;
	endtask

	function automatic logic [CHAR_W-1:0] rand_digit(bit nines);
		return CH_ZERO + (nines ? 8'd9 : CHAR_W'($urandom_range(9)));
	endfunction

	// Adds one character at the tail of the expression being built.
	function automatic void append_char(logic [CHAR_W-1:0] ch);
		expr_chars.insert(expr_chars.size(), ch);
	endfunction

	// Appends a number; a few are long enough to overflow the kept digits.
	function automatic void add_number_chars();
		int n_int;
		int n_frac;
		bit nines;
		n_int = ($urandom_range(9) == 0) ? $urandom_range(15, 21) : $urandom_range(1, 4);
		nines = ($urandom_range(3) == 0);
		repeat (n_int) append_char(rand_digit(nines));
		if ($urandom_range(2) == 0) begin
			append_char(CH_POINT);
			n_frac = ($urandom_range(9) == 0) ? $urandom_range(10, 20) : $urandom_range(1, 3);
			repeat (n_frac) append_char(rand_digit(nines));
		end
	endfunction

	// Appends a well-formed expression: terms joined by binary operators,
	// each term maybe negated, each a number or a bracketed subexpression.
	function automatic void add_expr_chars(int nest);
		int terms;
		terms = $urandom_range(1, 4);
		for (int i = 0; i < terms; i++) begin
			if (i > 0)
				append_char(ARITH_OPS[$urandom_range(3)]);
			if ($urandom_range(4) == 0)
				append_char(CH_MINUS);
			if (nest < 4 && $urandom_range(3) == 0) begin
				append_char(CH_OPEN);
				add_expr_chars(nest + 1);
				append_char(CH_CLOSE);
			end else begin
				add_number_chars();
			end
		end
	endfunction

	task automatic send_expr_chars();
		foreach (expr_chars[i])
			send_beat(OPN_CHAR, expr_chars[i]);
	endtask

	// Nests past the depth limit, then unwinds one more than it can.
	task automatic send_deep_nest();
		send_beat(OPN_CLEAR, '0);
		repeat (MAX_DEPTH + 3) send_beat(OPN_CHAR, CH_OPEN);
		send_beat(OPN_CHAR, rand_digit(1'b0));
		repeat (MAX_DEPTH + 1) send_beat(OPN_CHAR, CH_CLOSE);
		send_beat(OPN_END, '0);
	endtask

	initial begin
		int pick;
		int idx;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: refusals, every operator, unary minus, fractions,
		// a number flushed twice and an end with nothing pending.
		send_beat(OPN_UNUSED, CH_ALL_ONES);
		send_beat(OPN_END, '0);
		send_beat(OPN_CHAR, CH_ZERO + 8'd1);
		send_beat(OPN_CHAR, CH_CLOSE);          // close bracket at depth zero
		send_beat(OPN_CLEAR, '0);
		send_beat(OPN_CHAR, CH_MINUS);
		send_beat(OPN_CHAR, CH_OPEN);
		send_beat(OPN_CHAR, CH_ZERO);
		send_beat(OPN_CHAR, CH_POINT);
		send_beat(OPN_CHAR, CH_ZERO + 8'd5);
		send_beat(OPN_CHAR, CH_STAR);
		send_beat(OPN_CHAR, CH_NINE);
		send_beat(OPN_CHAR, CH_CLOSE);
		send_beat(OPN_CHAR, CH_SLASH);
		send_beat(OPN_CHAR, CH_LETTER_A);
		send_beat(OPN_CHAR, CH_ALL_ONES);
		send_beat(OPN_CHAR, CH_NUL);
		send_beat(OPN_CHAR, CH_ZERO + 8'd1);
		send_beat(OPN_END, '0);
		send_beat(OPN_CHAR, CH_PLUS);           // number already flushed by the end
		send_beat(OPN_CHAR, CH_ZERO + 8'd2);
		send_beat(OPN_END, '0);
		send_beat(OPN_END, '0);                 // nothing left to flush
		send_beat(OPN_CLEAR, '0);

		// Back-pressure: the receiver stops while a long nest streams in.
		hold_request = 1'b1;
		send_deep_nest();

		while (accepted_items < ITEM_TARGET) begin
			case ((accepted_items * 4) / ITEM_TARGET)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
				default: begin send_idle_pct = 8; recv_stall_pct = 8; end
			endcase
			pick = $urandom_range(99);
			expr_chars.delete();
			if (pick < 85) begin
				add_expr_chars(0);
				// Some expressions get a stray character or lose their tail.
				if (pick >= 70) begin
					idx = $urandom_range(expr_chars.size() - 1);
					if ($urandom_range(1))
						expr_chars[idx] = CHAR_W'($urandom_range(255));
					else
						while (expr_chars.size() > idx) void'(expr_chars.pop_back());
				end
				send_expr_chars();
				if ($urandom_range(9) != 0)
					send_beat(OPN_END, '0);
			end else begin
				repeat ($urandom_range(1, 8)) begin
					if ($urandom_range(15) == 0)
						send_beat(OPN_W'($urandom_range(3)), CHAR_W'($urandom_range(255)));
					else
						send_beat(OPN_CHAR, CHAR_W'($urandom_range(255)));
				end
			end
			if ($urandom_range(1))
				send_beat(OPN_CLEAR, CHAR_W'($urandom_range(255)));
		end
		s_tvalid <= 1'b0;

		while (board.awaited.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (board.errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
